>>> rtl/qmop_pkg.sv
// ----------------------------------------------------------------------------
// qmop_pkg
// Shared types and constants of the quadratic map orbit plotter.
// ----------------------------------------------------------------------------
package qmop_pkg;

  localparam int FRAME_WIDTH  = 256;
  localparam int FRAME_HEIGHT = 256;
  localparam int ESCAPE_LIMIT = 100;

  localparam int COL_W  = $clog2(FRAME_WIDTH);
  localparam int ROW_W  = $clog2(FRAME_HEIGHT);
  localparam int ADDR_W = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
  localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;

  // escape bound in Q8.24
  localparam int ESC_BOUND = ESCAPE_LIMIT * 16777216;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_BOT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_PPU    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_PPU    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW     = 3'd7;

  // item kinds
  localparam logic KIND_CLEAR = 1'b0;
  localparam logic KIND_RUN   = 1'b1;

  typedef struct packed {
    logic [31:0] coef_a;
    logic [31:0] coef_b;
    logic [31:0] window_left;
    logic [31:0] window_bottom;
    logic [31:0] x_pixels_per_unit;
    logic [31:0] y_pixels_per_unit;
    logic [7:0]  settle_steps;
    logic [5:0]  draw_steps;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] seed_x;
    logic [31:0] seed_y;
  } item_t;

endpackage

>>> rtl/quadratic_map_orbit_plotter.sv
// ----------------------------------------------------------------------------
// quadratic_map_orbit_plotter
// Iterates x'=c1*x-y*y, y'=c2*y+x*y from a seed and plots drawn points into
// a kept grey frame, reporting each drawn point.
//
// Input stream s_*: tuser is the kind (0 clear frame, 1 run seed), tdata
// carries the seed. A clear item gives no results; a run item gives one
// result per drawn step, cut short by an escape result, the final one with tlast.
// Output stream m_*: one report per result, held in an output register
// until taken; a stalled receiver stops the orbit engine at that point while
// the input queue still takes up to two items.
// Steps: an item starts from idle; a settling step runs the multiply and sum
// states, a drawn step runs multiply, sum, first and second mapping, memory read,
// shade and hand off, where a stalled receiver holds it.
// Defaults: 48 settling steps and 20 drawn steps.
// Reset loads the default registers and whitens the frame in a sweep over all 65536
// pixels, one pixel per cycle; a clear item takes the same sweep. Configuration
// writes take effect at once; the block leaves the user to make them while idle.
// ----------------------------------------------------------------------------
module quadratic_map_orbit_plotter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [qmop_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qmop_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [63:0]                     s_tdata,  // seed_x, seed_y
  input  logic                            s_tuser,  // kind
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,  // pixel_col, pixel_row, new_shade
  output logic [1:0]                      m_tuser,  // in_frame, escaped
  output logic                            m_tlast
);
  import qmop_pkg::*;

  cfg_t  cfg;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  qmop_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  qmop_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

>>> rtl/qmop_front.sv
// ----------------------------------------------------------------------------
// qmop_front
// Holds the configuration registers, accepts items and queues them for the
// orbit engine in a two-entry queue.
// ----------------------------------------------------------------------------
module qmop_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [qmop_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qmop_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [63:0]                     s_tdata,
  input  logic                            s_tuser,
  output qmop_pkg::cfg_t                  cfg,
  output logic                            q_valid,
  output qmop_pkg::item_t                 q_item,
  input  logic                            q_pop
);
  import qmop_pkg::*;

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_a            <= 32'hFEE66666;
      cfg.coef_b            <= 32'h01B850F6;
      cfg.window_left       <= 32'hFE400000;
      cfg.window_bottom     <= 32'hFE400000;
      cfg.x_pixels_per_unit <= 32'd4793490;
      cfg.y_pixels_per_unit <= 32'd4793490;
      cfg.settle_steps      <= 8'd48;
      cfg.draw_steps        <= 6'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_A:   cfg.coef_a            <= cfg_data;
        REG_COEF_B:   cfg.coef_b            <= cfg_data;
        REG_WIN_LEFT: cfg.window_left       <= cfg_data;
        REG_WIN_BOT:  cfg.window_bottom     <= cfg_data;
        REG_X_PPU:    cfg.x_pixels_per_unit <= cfg_data;
        REG_Y_PPU:    cfg.y_pixels_per_unit <= cfg_data;
        REG_SETTLE:   cfg.settle_steps      <= cfg_data[7:0];
        REG_DRAW:     cfg.draw_steps        <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entries[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{kind: s_tuser, seed_x: s_tdata[31:0], seed_y: s_tdata[63:32]};
    end
  end

  // advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/qmop_back.sv
// ----------------------------------------------------------------------------
// qmop_back
// Orbit engine: iterates the map, maps drawn points to pixels, darkens the
// frame memory, whitens it to clear, and hands results to the output register.
// ----------------------------------------------------------------------------
module qmop_back (
  input  logic            clk,
  input  logic            rst,
  input  qmop_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  qmop_pkg::item_t q_item,
  output logic            q_pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [23:0]     m_tdata,
  output logic [1:0]      m_tuser,
  output logic            m_tlast
);
  import qmop_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MUL, ST_SUM, ST_MAP1, ST_MAP2, ST_READ, ST_SHADE, ST_EMIT
  } state_t;

  state_t state;

  logic [7:0]        frame [PIXELS];
  logic [7:0]        mem_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [7:0]        mem_wd;

  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       x;
  logic [31:0]       y;
  logic [8:0]        it;
  logic [8:0]        total;
  logic              drawing;
  logic              lastit;

  logic signed [63:0] p_ax, p_yy, p_by, p_xy;
  logic [48:0]        px_hi, py_hi;
  logic [47:0]        px_lo, py_lo;
  logic               dx_neg, dy_neg;

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              hit;

  logic [7:0]  res_col, res_row, res_shade;
  logic        res_in, res_esc, res_last;

  logic signed [40:0] sum_x, sum_y;
  logic [31:0]        nx, ny;
  logic               esc;
  logic signed [32:0] dx, dy;
  logic [64:0]        prod_x, prod_y;
  logic [24:0]        tx;
  logic [25:0]        ceil_t;
  logic               col_ok, row_ok;
  logic [7:0]         shade_next;
  logic               slot_free;
  logic               emit_go;

  assign total     = 9'(cfg.settle_steps) + 9'(cfg.draw_steps);
  assign drawing   = (it >= 9'(cfg.settle_steps));
  assign lastit    = ((it + 9'd1) == total);
  assign slot_free = !m_tvalid || m_tready;
  assign emit_go   = (state == ST_EMIT) && slot_free;
  assign q_pop     = (state == ST_IDLE) && q_valid;

  // add floored products and saturate to 32 bits
  always_comb begin
    sum_x = 41'($signed(p_ax[63:24])) - 41'($signed(p_yy[63:24]));
    sum_y = 41'($signed(p_by[63:24])) + 41'($signed(p_xy[63:24]));
    if (sum_x > 41'sd2147483647) nx = 32'h7FFFFFFF;
    else if (sum_x < -41'sd2147483648) nx = 32'h80000000;
    else nx = sum_x[31:0];
    if (sum_y > 41'sd2147483647) ny = 32'h7FFFFFFF;
    else if (sum_y < -41'sd2147483648) ny = 32'h80000000;
    else ny = sum_y[31:0];
    esc = ($signed(nx) > ESC_BOUND) || ($signed(nx) < -ESC_BOUND) ||
          ($signed(ny) > ESC_BOUND) || ($signed(ny) < -ESC_BOUND);
  end

  // offsets from the window corner
  assign dx = 33'($signed(x)) - 33'($signed(cfg.window_left));
  assign dy = 33'($signed(y)) - 33'($signed(cfg.window_bottom));

  // join partial products and check frame bounds
  always_comb begin
    prod_x = {px_hi, 16'd0} + 65'(px_lo);
    prod_y = {py_hi, 16'd0} + 65'(py_lo);
    tx     = prod_x[64:40];
    ceil_t = 26'(prod_y[64:40]) + 26'(prod_y[39:0] != 40'd0);
    col_ok = !dx_neg && (tx < 25'(FRAME_WIDTH));
    row_ok = !dy_neg && (ceil_t >= 26'd1) && (ceil_t <= 26'(FRAME_HEIGHT));
  end

  assign shade_next = mem_q - {2'b00, mem_q[7:2]};

  // frame memory write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = rd_addr;
    mem_wd = shade_next;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = 8'hFF;
    end else if (state == ST_SHADE && hit) begin
      mem_we = 1'b1;
    end
  end

  // frame memory
  always_ff @(posedge clk) begin
    if (mem_we) frame[mem_wa] <= mem_wd;
    mem_q <= frame[rd_addr];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit_go) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(PIXELS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid) begin
            x  <= q_item.seed_x;
            y  <= q_item.seed_y;
            it <= '0;
            if (q_item.kind == KIND_CLEAR) begin
              clr_addr <= '0;
              state    <= ST_CLEAR;
            end else if (total != 9'd0) begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          p_ax  <= $signed(cfg.coef_a) * $signed(x);
          p_yy  <= $signed(y) * $signed(y);
          p_by  <= $signed(cfg.coef_b) * $signed(y);
          p_xy  <= $signed(x) * $signed(y);
          state <= ST_SUM;
        end
        ST_SUM: begin
          x <= nx;
          y <= ny;
          if (esc) begin
            res_col   <= '0;
            res_row   <= '0;
            res_shade <= '0;
            res_in    <= 1'b0;
            res_esc   <= 1'b1;
            res_last  <= 1'b1;
            state     <= ST_EMIT;
          end else if (drawing) begin
            res_esc  <= 1'b0;
            res_last <= lastit;
            state    <= ST_MAP1;
          end else begin
            it    <= it + 9'd1;
            state <= lastit ? ST_IDLE : ST_MUL;
          end
        end
        ST_MAP1: begin
          dx_neg <= dx[32];
          dy_neg <= dy[32];
          px_hi  <= 49'(dx[32:16]) * 49'(cfg.x_pixels_per_unit);
          px_lo  <= 48'(dx[15:0]) * 48'(cfg.x_pixels_per_unit);
          py_hi  <= 49'(dy[32:16]) * 49'(cfg.y_pixels_per_unit);
          py_lo  <= 48'(dy[15:0]) * 48'(cfg.y_pixels_per_unit);
          state  <= ST_MAP2;
        end
        ST_MAP2: begin
          hit     <= col_ok && row_ok;
          col     <= COL_W'(tx);
          row     <= ROW_W'(26'(FRAME_HEIGHT) - ceil_t);
          rd_addr <= ADDR_W'(ROW_W'(26'(FRAME_HEIGHT) - ceil_t) * FRAME_WIDTH)
                     + ADDR_W'(COL_W'(tx));
          state   <= ST_READ;
        end
        ST_READ: begin
          state <= ST_SHADE;
        end
        ST_SHADE: begin
          res_in    <= hit;
          res_col   <= hit ? 8'(col) : 8'd0;
          res_row   <= hit ? 8'(row) : 8'd0;
          res_shade <= hit ? shade_next : 8'd0;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            m_tdata  <= {res_shade, res_row, res_col};
            m_tuser  <= {res_esc, res_in};
            m_tlast  <= res_last;
            if (res_last) begin
              state <= ST_IDLE;
            end else begin
              it    <= it + 9'd1;
              state <= ST_MUL;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
